// ----- rtl/mtrd_pkg.sv -----
`default_nettype none

package mtrd_pkg;

    // field types
    typedef logic [1:0]  mode_t;
    typedef logic [1:0]  status_t;
    typedef logic [3:0]  log_t;
    typedef logic [15:0] rate_t;

    localparam int LOG_W = 4;

    // request kinds
    localparam mode_t MODE_TICK    = 2'd0;
    localparam mode_t MODE_SET     = 2'd1;
    localparam mode_t MODE_CONSUME = 2'd2;

    // result status codes
    localparam status_t STAT_OK      = 2'd0;
    localparam status_t STAT_BAD     = 2'd1;
    localparam status_t STAT_NONE    = 2'd2;

    // rate code is CODE_BASE minus log2 of the base rate
    localparam logic [4:0] CODE_BASE    = 5'd16;
    localparam log_t       MIN_RATE_LOG = 4'd1;
    localparam logic [7:0] PENDING_MAX  = 8'd255;

endpackage

`default_nettype wire

// ----- rtl/multichannel_tick_rate_divider.sv -----
`default_nettype none

// channel  | signals                                    | direction
// ---------+--------------------------------------------+----------
// request  | in_valid, in_stall, mode, channel, rate_hz | in
// result   | out_valid, out_stall, status, base_changed,| out
//          | rate_code, pending                         |
//
// one request per cycle sustained while the result is not stalled; a request
// is taken into the request register, and its result is loaded from there
// into the result register, which offers it
// a tick updates every channel counter at once in the single processing stage
// rst_n clears base rate and channel rates to 2 Hz, counters and events to 0
// a stalled result holds; the request register still takes one more request,
// after which in_stall rises until the result moves on

module multichannel_tick_rate_divider #(
    parameter int CHANNELS     = 4,
    parameter int MAX_RATE_LOG = 10
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire mtrd_pkg::mode_t   mode,
    input  wire logic [1:0]        channel,
    input  wire mtrd_pkg::rate_t   rate_hz,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output mtrd_pkg::status_t      status,
    output logic                   base_changed,
    output logic [3:0]             rate_code,
    output logic [7:0]             pending
);
    import mtrd_pkg::*;

    // counter holds at most base/rate - 1, below 2^(MAX_RATE_LOG-1)
    localparam int         CNT_W  = MAX_RATE_LOG - 1;
    localparam logic [4:0] CH_LIM = 5'(CHANNELS);
    localparam log_t       MAX_LG = LOG_W'(MAX_RATE_LOG);

    // request register
    logic        s1_valid_reg;
    mode_t       mode_reg;
    logic [1:0]  channel_reg;
    rate_t       rate_reg;

    // block state
    log_t              base_log_reg;
    log_t              base_log_next;
    log_t              rate_log_reg  [CHANNELS];
    log_t              rate_log_next [CHANNELS];
    logic [CNT_W-1:0]  tick_cnt_reg  [CHANNELS];
    logic [CNT_W-1:0]  tick_cnt_next [CHANNELS];
    logic [7:0]        pend_reg      [CHANNELS];
    logic [7:0]        pend_next     [CHANNELS];

    // result register
    logic        out_valid_reg;
    status_t     status_reg;
    status_t     status_next;
    logic        changed_reg;
    logic        changed_next;
    logic [3:0]  code_reg;
    logic [3:0]  code_next;
    logic [7:0]  pend_out_reg;
    logic [7:0]  pend_out_next;

    logic        s1_adv;
    logic        s1_fire;
    logic        in_fire;

    logic        ch_ok;
    logic        is_pow2;
    log_t        lg_raw;
    logic        lg_ok;
    logic [7:0]  pend_cur;
    logic [4:0]  code_wide;

    // handshake
    assign s1_adv    = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && s1_adv;
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_fire   = in_valid && !in_stall;

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign base_changed = changed_reg;
    assign rate_code    = code_reg;
    assign pending      = pend_out_reg;

    // rate check and log2 of a one-hot rate
    always_comb
    begin
        is_pow2 = (rate_reg != '0) && ((rate_reg & (rate_reg - 16'd1)) == '0);
        lg_raw  = '0;
        for (int b = 0; b < 16; b++)
        begin
            if (rate_reg[b])
            begin
                lg_raw = lg_raw | LOG_W'(b);
            end
        end
        lg_ok = is_pow2 && (lg_raw >= MIN_RATE_LOG) && (lg_raw <= MAX_LG);
        ch_ok = {3'b000, channel_reg} < CH_LIM;
    end

    // per-channel next state and result selection
    always_comb
    begin
        logic             hit;
        log_t             diff;
        logic [CNT_W:0]   sum;
        logic             wrap;

        base_log_next = base_log_reg;
        status_next   = STAT_OK;
        changed_next  = 1'b0;
        pend_cur      = '0;
        pend_out_next = '0;
        hit           = 1'b0;
        diff          = '0;
        sum           = '0;
        wrap          = 1'b0;

        for (int c = 0; c < CHANNELS; c++)
        begin
            if (5'(c) == {3'b000, channel_reg})
            begin
                pend_cur = pend_cur | pend_reg[c];
            end
        end

        // shared base rate and status
        unique case (mode_reg)
            MODE_TICK:
            begin
                status_next = STAT_OK;
            end
            MODE_SET:
            begin
                if (!lg_ok || !ch_ok)
                begin
                    status_next = STAT_BAD;
                end
                else if (lg_raw > base_log_reg)
                begin
                    base_log_next = lg_raw;
                    changed_next  = 1'b1;
                end
            end
            MODE_CONSUME:
            begin
                if (!ch_ok || pend_cur == '0)
                begin
                    status_next = STAT_NONE;
                end
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase

        for (int c = 0; c < CHANNELS; c++)
        begin
            hit  = 5'(c) == {3'b000, channel_reg};
            diff = (base_log_reg > rate_log_reg[c]) ? (base_log_reg - rate_log_reg[c]) : '0;
            sum  = {1'b0, tick_cnt_reg[c]} + (CNT_W + 1)'(1);
            wrap = (sum >> diff) != '0;

            rate_log_next[c] = rate_log_reg[c];
            tick_cnt_next[c] = tick_cnt_reg[c];
            pend_next[c]     = pend_reg[c];

            unique case (mode_reg)
                MODE_TICK:
                begin
                    tick_cnt_next[c] = wrap ? '0 : sum[CNT_W-1:0];
                    if (wrap && pend_reg[c] != PENDING_MAX)
                    begin
                        pend_next[c] = pend_reg[c] + 8'd1;
                    end
                end
                MODE_SET:
                begin
                    if (hit && lg_ok)
                    begin
                        rate_log_next[c] = lg_raw;
                        pend_next[c]     = '0;
                    end
                end
                MODE_CONSUME:
                begin
                    if (hit && pend_reg[c] != '0)
                    begin
                        pend_next[c] = pend_reg[c] - 8'd1;
                    end
                end
                default:
                begin
                    pend_next[c] = pend_reg[c];
                end
            endcase

            if (hit)
            begin
                pend_out_next = pend_out_next | pend_next[c];
            end
        end

        code_wide = CODE_BASE - {1'b0, base_log_next};
        code_next = code_wide[3:0];
    end

    // control and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            base_log_reg  <= MIN_RATE_LOG;
            for (int c = 0; c < CHANNELS; c++)
            begin
                rate_log_reg[c] <= MIN_RATE_LOG;
                tick_cnt_reg[c] <= '0;
                pend_reg[c]     <= '0;
            end
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_fire)
            begin
                base_log_reg <= base_log_next;
                for (int c = 0; c < CHANNELS; c++)
                begin
                    rate_log_reg[c] <= rate_log_next[c];
                    tick_cnt_reg[c] <= tick_cnt_next[c];
                    pend_reg[c]     <= pend_next[c];
                end
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg    <= mode;
            channel_reg <= channel;
            rate_reg    <= rate_hz;
        end
        if (s1_fire)
        begin
            status_reg   <= status_next;
            changed_reg  <= changed_next;
            code_reg     <= code_next;
            pend_out_reg <= pend_out_next;
        end
    end

endmodule

`default_nettype wire
